@@ rtl/tlat_pkg.sv @@
package tlat_pkg;

  // Datapath and table geometry
  localparam int SAMPLE_WIDTH = 16;
  localparam int ADDRESS_BITS = 14;
  localparam int FINE_BITS    = 3;
  localparam int COARSE_BITS  = ADDRESS_BITS - FINE_BITS;
  localparam int FINE_DEPTH   = 1 << ADDRESS_BITS;
  localparam int COARSE_DEPTH = 1 << COARSE_BITS;

  // Input item fields
  localparam int MODE_WIDTH  = 2;
  localparam int INDEX_WIDTH = 14;
  localparam int WORD_WIDTH  = 16;

  // Stream payload widths, padded to whole bytes
  localparam int IN_BITS     = SAMPLE_WIDTH + INDEX_WIDTH + WORD_WIDTH;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_LOW_LIMIT       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_LIMIT      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LINEAR_ABOVE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SYMMETRIC_MODE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MIRROR_CONSTANT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BELOW_VALUE     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_ABOVE_VALUE     = 3'd6;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_EVAL   = 2'd0,
    MODE_FINE   = 2'd1,
    MODE_COARSE = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  // How the back end forms a result
  typedef enum logic {
    KIND_CONST = 1'b0,
    KIND_TABLE = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] low_limit;
    logic signed [SAMPLE_WIDTH-1:0] high_limit;
    logic                           linear_above;
    logic                           symmetric_mode;
    logic signed [SAMPLE_WIDTH-1:0] mirror_constant;
    logic signed [SAMPLE_WIDTH-1:0] below_value;
    logic signed [SAMPLE_WIDTH-1:0] above_value;
  } cfg_t;

  // Table port requests from the front end
  typedef struct packed {
    logic                    coarse_we;
    logic [COARSE_BITS-1:0]  coarse_addr;
    logic [SAMPLE_WIDTH-1:0] coarse_wdata;
    logic                    fine_we;
    logic [ADDRESS_BITS-1:0] fine_addr;
    logic [FINE_BITS-1:0]    fine_wdata;
  } ram_req_t;

  // Classified evaluate beat, waiting for table data
  typedef struct packed {
    logic                    valid;
    kind_t                   kind;
    logic [SAMPLE_WIDTH-1:0] const_value;
    logic                    mirror;
  } stage_t;

  typedef struct packed {
    kind_t                   kind;
    logic [SAMPLE_WIDTH-1:0] const_value;
    logic                    mirror;
    logic [SAMPLE_WIDTH-1:0] coarse;
    logic [FINE_BITS-1:0]    fine;
  } entry_t;

endpackage

@@ rtl/tlat_ram.sv @@
module tlat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/tlat_front.sv @@
module tlat_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic [tlat_pkg::MODE_WIDTH-1:0]      mode,
  input  logic [tlat_pkg::SAMPLE_WIDTH-1:0]    sample,
  input  logic [tlat_pkg::INDEX_WIDTH-1:0]     table_index,
  input  logic [tlat_pkg::WORD_WIDTH-1:0]      table_word,
  input  tlat_pkg::cfg_t                       cfg,
  output tlat_pkg::ram_req_t                   ram_req,
  output tlat_pkg::stage_t                     stage
);

  logic                                  is_eval;
  logic                                  is_below;
  logic                                  is_above;
  logic                                  neg;
  logic [tlat_pkg::SAMPLE_WIDTH-1:0]     target;
  logic [tlat_pkg::ADDRESS_BITS-1:0]     addr;
  logic                                  coarse_in_range;
  tlat_pkg::kind_t                       kind;
  logic [tlat_pkg::SAMPLE_WIDTH-1:0]     const_value;

  assign is_eval = (tlat_pkg::mode_t'(mode) == tlat_pkg::MODE_EVAL);

  // Range classification against the thresholds
  assign is_below = $signed(sample) < cfg.low_limit;
  assign is_above = $signed(sample) > cfg.high_limit;
  assign neg      = sample[tlat_pkg::SAMPLE_WIDTH-1];

  // Table address: absolute value or offset from the lower threshold, wrapping
  always_comb begin
    if (cfg.symmetric_mode) begin
      target = neg ? (~sample + 1'b1) : sample;
    end else begin
      target = sample - cfg.low_limit;
    end
  end

  assign addr = target[tlat_pkg::ADDRESS_BITS-1:0];

  always_comb begin
    if (is_below) begin
      kind        = tlat_pkg::KIND_CONST;
      const_value = cfg.below_value;
    end else if (is_above) begin
      kind        = tlat_pkg::KIND_CONST;
      const_value = cfg.linear_above ? sample : cfg.above_value;
    end else begin
      kind        = tlat_pkg::KIND_TABLE;
      const_value = cfg.below_value;
    end
  end

  // Coarse writes beyond the table depth are dropped
  assign coarse_in_range =
    (table_index[tlat_pkg::INDEX_WIDTH-1:tlat_pkg::COARSE_BITS] == '0);

  // Table ports: a write beat writes, an evaluate beat reads
  always_comb begin
    ram_req.coarse_we    = accept && (tlat_pkg::mode_t'(mode) == tlat_pkg::MODE_COARSE)
                           && coarse_in_range;
    ram_req.fine_we      = accept && (tlat_pkg::mode_t'(mode) == tlat_pkg::MODE_FINE);
    ram_req.coarse_wdata = table_word[tlat_pkg::SAMPLE_WIDTH-1:0];
    ram_req.fine_wdata   = table_word[tlat_pkg::FINE_BITS-1:0];
    if (is_eval) begin
      ram_req.coarse_addr = addr[tlat_pkg::ADDRESS_BITS-1:tlat_pkg::FINE_BITS];
      ram_req.fine_addr   = addr;
    end else begin
      ram_req.coarse_addr = table_index[tlat_pkg::COARSE_BITS-1:0];
      ram_req.fine_addr   = table_index[tlat_pkg::ADDRESS_BITS-1:0];
    end
  end

  // Classified beat waits here while the tables are read
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= accept && is_eval;
    end
    stage.kind        <= kind;
    stage.const_value <= const_value;
    stage.mirror      <= cfg.symmetric_mode && neg;
  end

endmodule

@@ rtl/tlat_queue.sv @@
module tlat_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  tlat_pkg::entry_t                   push_entry,
  input  logic                               pop,
  output tlat_pkg::entry_t                   head,
  output logic                               not_empty,
  output logic [tlat_pkg::QUEUE_CNT_W-1:0]   count
);

  tlat_pkg::entry_t                    entries [tlat_pkg::QUEUE_DEPTH];
  logic [tlat_pkg::QUEUE_PTR_W-1:0]    wr_ptr;
  logic [tlat_pkg::QUEUE_PTR_W-1:0]    rd_ptr;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ rtl/tlat_back.sv @@
module tlat_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tlat_pkg::entry_t                      head,
  input  logic                                  head_valid,
  input  logic [tlat_pkg::SAMPLE_WIDTH-1:0]     mirror_constant,
  input  logic                                  out_ready,
  output logic                                  pop,
  output logic                                  out_valid,
  output logic [tlat_pkg::SAMPLE_WIDTH-1:0]     out_word
);

  logic [tlat_pkg::SAMPLE_WIDTH-1:0] lut;
  logic [tlat_pkg::SAMPLE_WIDTH-1:0] result;

  // Coarse word plus zero-extended fine offset, then optional mirror
  assign lut = head.coarse
               + {{(tlat_pkg::SAMPLE_WIDTH - tlat_pkg::FINE_BITS){1'b0}}, head.fine};

  always_comb begin
    if (head.kind == tlat_pkg::KIND_TABLE) begin
      result = head.mirror ? (mirror_constant - lut) : lut;
    end else begin
      result = head.const_value;
    end
  end

  // Output register refills when empty or when its beat is taken
  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= result;
    end
  end

endmodule

@@ rtl/two_level_table_activation_unit.sv @@
// Path: an evaluate beat accepted on s_tdata passes the table read, the queue write
//   and the output register, in that order, and may wait there for m_tready.
// Throughput: one beat per cycle when ready, write beats included; writes give no output.
// Back pressure: s_tready drops once queued entries plus the read stage beat reach four.
// Reset: rst is synchronous; clears the queue, output valid and all config registers.
//   Table contents are undefined until written.
module two_level_table_activation_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration
  input  logic                                 cfg_we,
  input  logic [tlat_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [tlat_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // Input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [tlat_pkg::IN_TDATA_W-1:0]      s_tdata,   // sample, table_index, table_word
  input  logic [tlat_pkg::MODE_WIDTH-1:0]      s_tuser,   // mode
  // Output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [tlat_pkg::OUT_TDATA_W-1:0]     m_tdata    // result
);

  localparam int SampleLo = 0;
  localparam int IndexLo  = SampleLo + tlat_pkg::SAMPLE_WIDTH;
  localparam int WordLo   = IndexLo + tlat_pkg::INDEX_WIDTH;

  tlat_pkg::cfg_t                            cfg;
  tlat_pkg::ram_req_t                        ram_req;
  tlat_pkg::stage_t                          stage;
  tlat_pkg::entry_t                          push_entry;
  tlat_pkg::entry_t                          head;
  logic                                      s_accept;
  logic                                      q_push;
  logic                                      q_pop;
  logic                                      q_not_empty;
  logic [tlat_pkg::QUEUE_CNT_W-1:0]          q_count;
  logic [tlat_pkg::QUEUE_CNT_W:0]            in_flight;
  logic [tlat_pkg::SAMPLE_WIDTH-1:0]         coarse_rdata;
  logic [tlat_pkg::FINE_BITS-1:0]            fine_rdata;
  logic [tlat_pkg::SAMPLE_WIDTH-1:0]         result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tlat_pkg::REG_LOW_LIMIT:       cfg.low_limit       <= cfg_wdata;
        tlat_pkg::REG_HIGH_LIMIT:      cfg.high_limit      <= cfg_wdata;
        tlat_pkg::REG_LINEAR_ABOVE:    cfg.linear_above    <= cfg_wdata[0];
        tlat_pkg::REG_SYMMETRIC_MODE:  cfg.symmetric_mode  <= cfg_wdata[0];
        tlat_pkg::REG_MIRROR_CONSTANT: cfg.mirror_constant <= cfg_wdata;
        tlat_pkg::REG_BELOW_VALUE:     cfg.below_value     <= cfg_wdata;
        tlat_pkg::REG_ABOVE_VALUE:     cfg.above_value     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Accept while the queue has room for everything already in flight
  assign in_flight = {1'b0, q_count} + (tlat_pkg::QUEUE_CNT_W + 1)'(stage.valid);
  assign s_tready  = in_flight < (tlat_pkg::QUEUE_CNT_W + 1)'(tlat_pkg::QUEUE_DEPTH);
  assign s_accept  = s_tvalid && s_tready;

  tlat_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (s_accept),
    .mode        (s_tuser),
    .sample      (s_tdata[SampleLo +: tlat_pkg::SAMPLE_WIDTH]),
    .table_index (s_tdata[IndexLo +: tlat_pkg::INDEX_WIDTH]),
    .table_word  (s_tdata[WordLo +: tlat_pkg::WORD_WIDTH]),
    .cfg         (cfg),
    .ram_req     (ram_req),
    .stage       (stage)
  );

  tlat_ram #(
    .WIDTH (tlat_pkg::SAMPLE_WIDTH),
    .DEPTH (tlat_pkg::COARSE_DEPTH)
  ) u_coarse_ram (
    .clk   (clk),
    .we    (ram_req.coarse_we),
    .addr  (ram_req.coarse_addr),
    .wdata (ram_req.coarse_wdata),
    .rdata (coarse_rdata)
  );

  tlat_ram #(
    .WIDTH (tlat_pkg::FINE_BITS),
    .DEPTH (tlat_pkg::FINE_DEPTH)
  ) u_fine_ram (
    .clk   (clk),
    .we    (ram_req.fine_we),
    .addr  (ram_req.fine_addr),
    .wdata (ram_req.fine_wdata),
    .rdata (fine_rdata)
  );

  // Join the classified beat with its table data
  assign q_push = stage.valid;

  always_comb begin
    push_entry.kind        = stage.kind;
    push_entry.const_value = stage.const_value;
    push_entry.mirror      = stage.mirror;
    push_entry.coarse      = coarse_rdata;
    push_entry.fine        = fine_rdata;
  end

  tlat_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .not_empty  (q_not_empty),
    .count      (q_count)
  );

  tlat_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .head_valid      (q_not_empty),
    .mirror_constant (cfg.mirror_constant),
    .out_ready       (m_tready),
    .pop             (q_pop),
    .out_valid       (m_tvalid),
    .out_word        (result)
  );

  assign m_tdata = tlat_pkg::OUT_TDATA_W'(result);

  // Queue never receives a beat when full
  assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < tlat_pkg::QUEUE_CNT_W'(tlat_pkg::QUEUE_DEPTH)))
    else $error("queue overflow");

  // Every accepted evaluate beat enters the queue in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && (tlat_pkg::mode_t'(s_tuser) == tlat_pkg::MODE_EVAL)) |=> q_push)
    else $error("evaluate beat lost before queue");

  // Write and unused beats never produce a queue entry
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && (tlat_pkg::mode_t'(s_tuser) != tlat_pkg::MODE_EVAL)) |=> !q_push)
    else $error("non-evaluate beat produced a result");

endmodule

@@ sim/activation_checker.sv @@
`timescale 1ns / 100ps

// Watches the config port and both streams, keeps its own copy of the
// settings and tables, and compares every output beat with the oldest
// predicted activation.
module activation_checker
  import tlat_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample, table_index, table_word
  input  logic [MODE_WIDTH-1:0]  s_tuser,   // mode
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // result
  output int                     mismatch_count,
  output int                     results_pending
);

  cfg_t                    settings;
  logic [SAMPLE_WIDTH-1:0] coarse_words [COARSE_DEPTH];
  logic [FINE_BITS-1:0]    fine_offsets [FINE_DEPTH];
  logic [SAMPLE_WIDTH-1:0] expected_activations [$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  // Function value for one sample under the current settings
  function automatic logic [SAMPLE_WIDTH-1:0] activation_of(input logic [SAMPLE_WIDTH-1:0] x);
    logic [SAMPLE_WIDTH-1:0] target;
    logic [ADDRESS_BITS-1:0] addr;
    logic [SAMPLE_WIDTH-1:0] lut;
    if ($signed(x) < $signed(settings.low_limit)) return settings.below_value;
    if ($signed(x) > $signed(settings.high_limit))
      return settings.linear_above ? x : settings.above_value;
    if (settings.symmetric_mode) target = x[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(0) - x : x;
    else target = x - settings.low_limit;
    addr = target[ADDRESS_BITS-1:0];
    lut = coarse_words[addr[ADDRESS_BITS-1:FINE_BITS]]
        + SAMPLE_WIDTH'(fine_offsets[addr]);
    // in symmetric mode, negative samples mirror around the constant
    if (settings.symmetric_mode && x[SAMPLE_WIDTH-1]) return settings.mirror_constant - lut;
    return lut;
  endfunction

  task automatic flag_mismatch(input string what, input logic [SAMPLE_WIDTH-1:0] want,
                               input logic [SAMPLE_WIDTH-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    logic [SAMPLE_WIDTH-1:0] sample;
    logic [INDEX_WIDTH-1:0]  index;
    logic [WORD_WIDTH-1:0]   word;
    logic [SAMPLE_WIDTH-1:0] want;
    if (rst) begin
      settings = '0;
      expected_activations.delete();
    end else begin
      // result beats, oldest expectation first
      if (m_tvalid && m_tready) begin
        if (expected_activations.size() == 0) begin
          flag_mismatch("result beat with nothing expected", 'x, m_tdata[SAMPLE_WIDTH-1:0]);
        end else begin
          want = expected_activations.pop_front();
          if (m_tdata[SAMPLE_WIDTH-1:0] !== want)
            flag_mismatch("result mismatch", want, m_tdata[SAMPLE_WIDTH-1:0]);
        end
      end

      // input beats
      if (s_tvalid && s_tready) begin
        sample = s_tdata[SAMPLE_WIDTH-1:0];
        index  = s_tdata[SAMPLE_WIDTH +: INDEX_WIDTH];
        word   = s_tdata[SAMPLE_WIDTH + INDEX_WIDTH +: WORD_WIDTH];
        case (mode_t'(s_tuser))
          MODE_EVAL: begin
            expected_activations.push_back(activation_of(sample));
          end
          MODE_FINE: begin
            fine_offsets[index] = word[FINE_BITS-1:0];
          end
          MODE_COARSE: begin
            if (index < COARSE_DEPTH) coarse_words[index[COARSE_BITS-1:0]] = word;
          end
          default: ;
        endcase
      end

      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_LOW_LIMIT:       settings.low_limit       = cfg_wdata;
          REG_HIGH_LIMIT:      settings.high_limit      = cfg_wdata;
          REG_LINEAR_ABOVE:    settings.linear_above    = cfg_wdata[0];
          REG_SYMMETRIC_MODE:  settings.symmetric_mode  = cfg_wdata[0];
          REG_MIRROR_CONSTANT: settings.mirror_constant = cfg_wdata;
          REG_BELOW_VALUE:     settings.below_value     = cfg_wdata;
          REG_ABOVE_VALUE:     settings.above_value     = cfg_wdata;
          default: ;
        endcase
      end
    end
    results_pending = expected_activations.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import tlat_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // sample, table_index, table_word
  logic [MODE_WIDTH-1:0]  s_tuser;   // mode
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // result

  int mismatch_count;
  int results_pending;

  // Stimulus-side view of the settings and of which entries hold data
  cfg_t dut_cfg;
  bit   coarse_written [COARSE_DEPTH];
  bit   fine_written   [FINE_DEPTH];
  bit   idle_enable;

  two_level_table_activation_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  activation_checker activation_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stall before each beat
  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    forever begin
      stall = idle_enable ? $urandom_range(0, 6) : 0;
      @(negedge clk);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // One input beat; valid stays up across back-to-back beats
  task automatic send_beat(input mode_t mode, input logic [SAMPLE_WIDTH-1:0] sample,
                           input logic [INDEX_WIDTH-1:0] index,
                           input logic [WORD_WIDTH-1:0] word);
    int gap;
    gap = idle_enable ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= IN_TDATA_W'({word, index, sample});
    do @(posedge clk); while (!s_tready);
    if (mode == MODE_FINE) fine_written[index] = 1'b1;
    if (mode == MODE_COARSE && index < COARSE_DEPTH) coarse_written[index] = 1'b1;
  endtask

  // Drop valid and wait until every expected result is out and the pipe drains
  task automatic quiesce();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (results_pending == 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_settings(input cfg_t c);
    quiesce();
    write_register(REG_LOW_LIMIT,       c.low_limit);
    write_register(REG_HIGH_LIMIT,      c.high_limit);
    write_register(REG_LINEAR_ABOVE,    CFG_DATA_W'(c.linear_above));
    write_register(REG_SYMMETRIC_MODE,  CFG_DATA_W'(c.symmetric_mode));
    write_register(REG_MIRROR_CONSTANT, c.mirror_constant);
    write_register(REG_BELOW_VALUE,     c.below_value);
    write_register(REG_ABOVE_VALUE,     c.above_value);
    dut_cfg = c;
  endtask

  // Table address a sample reads, if it reaches the tables at all
  function automatic bit reads_table(input logic [SAMPLE_WIDTH-1:0] x,
                                     output logic [ADDRESS_BITS-1:0] addr);
    logic [SAMPLE_WIDTH-1:0] target;
    addr = '0;
    if ($signed(x) < $signed(dut_cfg.low_limit) ||
        $signed(x) > $signed(dut_cfg.high_limit)) return 1'b0;
    if (dut_cfg.symmetric_mode) target = x[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(0) - x : x;
    else target = x - dut_cfg.low_limit;
    addr = target[ADDRESS_BITS-1:0];
    return 1'b1;
  endfunction

  // Evaluate a sample, filling any entry it reads that holds no data yet
  task automatic evaluate(input logic [SAMPLE_WIDTH-1:0] x);
    logic [ADDRESS_BITS-1:0] addr;
    if (reads_table(x, addr)) begin
      if (!fine_written[addr])
        send_beat(MODE_FINE, 16'($urandom), addr, 16'($urandom));
      if (!coarse_written[addr[ADDRESS_BITS-1:FINE_BITS]])
        send_beat(MODE_COARSE, 16'($urandom), INDEX_WIDTH'(addr[ADDRESS_BITS-1:FINE_BITS]),
                  16'($urandom));
    end
    send_beat(MODE_EVAL, x, 14'($urandom), 16'($urandom));
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    logic [15:0] swap;
    c.low_limit  = pick_level();
    c.high_limit = pick_level();
    // mostly a proper window; sometimes an empty one
    if ($signed(c.low_limit) > $signed(c.high_limit) && $urandom_range(0, 3) != 0) begin
      swap = c.low_limit;
      c.low_limit = c.high_limit;
      c.high_limit = swap;
    end
    c.linear_above    = 1'($urandom_range(0, 1));
    c.symmetric_mode  = 1'($urandom_range(0, 1));
    c.mirror_constant = pick_level();
    c.below_value     = pick_level();
    c.above_value     = pick_level();
    return c;
  endfunction

  // Mostly inside the window, some at the thresholds, some anywhere
  function automatic logic [15:0] random_sample();
    int lo;
    int hi;
    lo = $signed(dut_cfg.low_limit);
    hi = $signed(dut_cfg.high_limit);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        if (lo <= hi) return 16'(lo + $urandom_range(0, hi - lo));
        return 16'($urandom);
      end
      5: return 16'(lo + $urandom_range(0, 4) - 2);
      6: return 16'(hi + $urandom_range(0, 4) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    cfg_t c;
    int   pick;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = MODE_EVAL;
    idle_enable = 1'b1;
    dut_cfg     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: out-of-range coarse writes must not alias entry 0
    send_beat(MODE_FINE,   16'h0000, 14'd0,     16'hFFFF);
    send_beat(MODE_COARSE, 16'h0000, 14'd0,     16'h1234);
    send_beat(MODE_COARSE, 16'h0000, 14'd2048,  16'hBEEF);
    send_beat(MODE_COARSE, 16'h0000, 14'h3FFF,  16'hFFFF);
    send_beat(MODE_UNUSED, 16'hFFFF, 14'h3FFF,  16'hFFFF);
    evaluate(16'h0000);
    evaluate(16'hFFFF);
    evaluate(16'h0001);

    // Full window, offset addressing: top entries and carry wrap
    c = '0;
    c.low_limit  = 16'h8000;
    c.high_limit = 16'h7FFF;
    apply_settings(c);
    send_beat(MODE_FINE,   16'h0000, 14'h3FFF,  16'hFFFF);
    send_beat(MODE_COARSE, 16'h0000, 14'd2047,  16'hFFFF);
    evaluate(16'h7FFF);
    evaluate(16'h8000);

    // Symmetric: most negative sample wraps under absolute value
    c.symmetric_mode  = 1'b1;
    c.mirror_constant = 16'h7FFF;
    apply_settings(c);
    evaluate(16'h8000);
    evaluate(16'hFFFF);
    evaluate(16'h7FFF);
    evaluate(16'h0000);

    // Narrow window with pass-through above
    c.low_limit       = 16'(-100);
    c.high_limit      = 16'd200;
    c.linear_above    = 1'b1;
    c.symmetric_mode  = 1'b0;
    c.below_value     = 16'h8000;
    c.above_value     = 16'h7FFF;
    apply_settings(c);
    evaluate(16'h8000);
    evaluate(16'(-101));
    evaluate(16'(-100));
    evaluate(16'd200);
    evaluate(16'd201);
    evaluate(16'h7FFF);

    // Constant above, mirrored negatives
    c.linear_above    = 1'b0;
    c.symmetric_mode  = 1'b1;
    c.mirror_constant = 16'h8000;
    apply_settings(c);
    evaluate(16'(-100));
    evaluate(16'd201);
    evaluate(16'(-50));

    // Random phases, some with no idling on either side
    for (int phase = 0; phase < 6; phase++) begin
      apply_settings(random_settings());
      idle_enable = (phase % 3) != 2;
      for (int n = 0; n < 80; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 12 || pick == 19) begin
          evaluate(random_sample());
        end else if (pick < 15) begin
          send_beat(MODE_FINE, 16'($urandom), 14'($urandom), 16'($urandom));
        end else if (pick < 18) begin
          if ($urandom_range(0, 9) == 0)
            send_beat(MODE_COARSE, 16'($urandom), 14'($urandom), 16'($urandom));
          else
            send_beat(MODE_COARSE, 16'($urandom), 14'($urandom_range(0, COARSE_DEPTH - 1)),
                      16'($urandom));
        end else begin
          send_beat(MODE_UNUSED, 16'($urandom), 14'($urandom), 16'($urandom));
        end
      end
    end

    quiesce();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
